// ===== sv/bfc_pkg.sv =====
`timescale 1ns / 1ps

package bfc_pkg;

    localparam int COEF_W      = 16;
    localparam int ROW_W       = 64;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_COLS    = 4;
    localparam int NUM_CORNERS = 8;
    localparam int NUM_PLANES  = 6;
    localparam int SCALE_W     = 15;
    localparam int OFFSET_W    = 16;
    localparam int HH_W        = 15;
    localparam int PROD_W      = 32;
    localparam int BASE_W      = 34;
    localparam int CLIP_W      = 38;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 8;

    localparam logic [HH_W-1:0] HH_RESET = HH_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW3        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd4;

    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_Z = 2;
    localparam int ROW_W_IDX = 3;

    localparam int PL_LEFT   = 0;
    localparam int PL_RIGHT  = 1;
    localparam int PL_BOTTOM = 2;
    localparam int PL_TOP    = 3;
    localparam int PL_NEAR   = 4;
    localparam int PL_FAR    = 5;

    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        logic signed [BASE_W-1:0] base;
        logic signed [PROD_W-1:0] x_step;
        logic signed [PROD_W-1:0] y_half;
        logic signed [PROD_W-1:0] z_step;
    } t_terms;

endpackage

// ===== sv/bfc_xform.sv =====
`timescale 1ns / 1ps

module bfc_xform (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  bfc_pkg::t_row                i_row,
    input  logic [bfc_pkg::HH_W-1:0]     i_half_height,
    input  logic [bfc_pkg::SCALE_W-1:0]  i_tile_scale,
    input  logic signed [bfc_pkg::OFFSET_W-1:0] i_offset_x,
    input  logic signed [bfc_pkg::OFFSET_W-1:0] i_offset_z,
    output bfc_pkg::t_terms              o_terms
);
    import bfc_pkg::*;

    logic signed [COEF_W-1:0] w_cx;
    logic signed [COEF_W-1:0] w_cy;
    logic signed [COEF_W-1:0] w_cz;
    logic signed [COEF_W-1:0] w_cw;
    logic signed [COEF_W-1:0] w_scale;
    logic signed [COEF_W-1:0] w_hh;
    logic signed [PROD_W-1:0] w_p_ox;
    logic signed [PROD_W-1:0] w_p_oz;
    logic signed [PROD_W-1:0] w_p_hh;
    logic signed [PROD_W-1:0] w_p_sx;
    logic signed [PROD_W-1:0] w_p_sz;
    t_terms                   n_terms;
    t_terms                   r_terms;

    assign w_cx    = signed'(i_row[0*COEF_W +: COEF_W]);
    assign w_cy    = signed'(i_row[1*COEF_W +: COEF_W]);
    assign w_cz    = signed'(i_row[2*COEF_W +: COEF_W]);
    assign w_cw    = signed'(i_row[3*COEF_W +: COEF_W]);
    assign w_scale = signed'({1'b0, i_tile_scale});
    assign w_hh    = signed'({1'b0, i_half_height});

    assign w_p_ox = w_cx * i_offset_x;
    assign w_p_oz = w_cz * i_offset_z;
    assign w_p_hh = w_cy * w_hh;
    assign w_p_sx = w_cx * w_scale;
    assign w_p_sz = w_cz * w_scale;

    // base is the corner at i=0, j=0, y=-half_height
    always_comb begin
        n_terms.base   = BASE_W'(w_p_ox) + BASE_W'(w_p_oz) + BASE_W'(w_cw)
                       - BASE_W'(w_p_hh);
        n_terms.x_step = w_p_sx;
        n_terms.y_half = w_p_hh;
        n_terms.z_step = w_p_sz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

// ===== sv/bfc_clip.sv =====
`timescale 1ns / 1ps

module bfc_clip (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  bfc_pkg::t_terms [bfc_pkg::NUM_ROWS-1:0]    i_terms,
    output logic [bfc_pkg::NUM_PLANES-1:0]             o_plane_mask
);
    import bfc_pkg::*;

    logic [NUM_PLANES-1:0] n_mask;
    logic [NUM_PLANES-1:0] r_mask;

    always_comb begin
        logic signed [CLIP_W-1:0] c [NUM_ROWS];
        logic signed [CLIP_W-1:0] neg_w;
        logic [NUM_PLANES-1:0]    all_out;
        all_out = '1;
        for (int n = 0; n < NUM_CORNERS; n++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                c[r] = CLIP_W'(i_terms[r].base)
                     + (n[2] ? CLIP_W'(i_terms[r].x_step) : CLIP_W'(0))
                     + (n[0] ? (CLIP_W'(i_terms[r].y_half) <<< 1) : CLIP_W'(0))
                     + (n[1] ? CLIP_W'(i_terms[r].z_step) : CLIP_W'(0));
            end
            neg_w = -c[ROW_W_IDX];
            all_out[PL_LEFT]   = all_out[PL_LEFT]   & (c[ROW_X] < neg_w);
            all_out[PL_RIGHT]  = all_out[PL_RIGHT]  & (c[ROW_X] > c[ROW_W_IDX]);
            all_out[PL_BOTTOM] = all_out[PL_BOTTOM] & (c[ROW_Y] < neg_w);
            all_out[PL_TOP]    = all_out[PL_TOP]    & (c[ROW_Y] > c[ROW_W_IDX]);
            all_out[PL_NEAR]   = all_out[PL_NEAR]   & (c[ROW_Z] < neg_w);
            all_out[PL_FAR]    = all_out[PL_FAR]    & (c[ROW_Z] > c[ROW_W_IDX]);
        end
        n_mask = all_out;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mask <= n_mask;
        end
    end

    assign o_plane_mask = r_mask;

endmodule

// ===== sv/box_frustum_cull_unit.sv =====
`timescale 1ns / 1ps

// Clip-space cull test for one square terrain tile per transfer. The eight
// box corners are run through the configured 4x4 Q8.8 matrix with exact
// integer sums, and the result reports which of the six planes (left,
// right, bottom, top, near, far) have all corners strictly outside. One
// tile is taken every cycle unless a stalled output fills the stages.
// A result passes the input register, product stage and plane test
// stage in turn; stages hold only while the output is stalled and full.
// Configuration is taken at any cycle and must be written while idle.

module box_frustum_cull_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bfc_pkg::ROW_W-1:0]         i_cfg_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tile_scale[14:0], offset_x[30:15], offset_z[46:31], zero[47]
    input  logic [bfc_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // culled[0], plane_mask[6:1], zero[7]
    output logic [bfc_pkg::OUT_DATA_W-1:0]    o_m_tdata
);
    import bfc_pkg::*;

    t_row                        r_row [NUM_ROWS];
    logic [HH_W-1:0]             r_half_height;
    logic [SCALE_W-1:0]          r_scale;
    logic signed [OFFSET_W-1:0]  r_ox;
    logic signed [OFFSET_W-1:0]  r_oz;
    logic                        r_in_vld;
    logic                        r_prod_vld;
    logic                        r_out_vld;
    logic                        w_out_move;
    logic                        w_prod_move;
    logic                        w_in_move;
    t_terms [NUM_ROWS-1:0]       w_terms;
    logic [NUM_PLANES-1:0]       w_mask;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_row[r] <= '0;
            end
            r_half_height <= HH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROW0:        r_row[0]      <= i_cfg_data;
                CFG_ROW1:        r_row[1]      <= i_cfg_data;
                CFG_ROW2:        r_row[2]      <= i_cfg_data;
                CFG_ROW3:        r_row[3]      <= i_cfg_data;
                CFG_HALF_HEIGHT: r_half_height <= i_cfg_data[HH_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_out_move  = !r_out_vld || i_m_tready;
    assign w_prod_move = !r_prod_vld || w_out_move;
    assign w_in_move   = !r_in_vld || w_prod_move;
    assign o_s_tready  = w_in_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_in_move) begin
                r_in_vld <= i_s_tvalid;
            end
            if (w_prod_move) begin
                r_prod_vld <= r_in_vld;
            end
            if (w_out_move) begin
                r_out_vld <= r_prod_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_move && i_s_tvalid) begin
            r_scale <= i_s_tdata[SCALE_W-1:0];
            r_ox    <= signed'(i_s_tdata[SCALE_W +: OFFSET_W]);
            r_oz    <= signed'(i_s_tdata[SCALE_W+OFFSET_W +: OFFSET_W]);
        end
    end

    for (genvar g = 0; g < NUM_ROWS; g++) begin : g_row
        bfc_xform u_xform (
            .i_clk         (i_clk),
            .i_en          (w_prod_move),
            .i_row         (r_row[g]),
            .i_half_height (r_half_height),
            .i_tile_scale  (r_scale),
            .i_offset_x    (r_ox),
            .i_offset_z    (r_oz),
            .o_terms       (w_terms[g])
        );
    end

    bfc_clip u_clip (
        .i_clk        (i_clk),
        .i_en         (w_out_move),
        .i_terms      (w_terms),
        .o_plane_mask (w_mask)
    );

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, w_mask, |w_mask};

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bfc_pkg::*;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] offset_z;
        logic signed [OFFSET_W-1:0] offset_x;
        logic [SCALE_W-1:0]         tile_scale;
    } t_tile;

    typedef struct packed {
        logic                  pad;
        logic [NUM_PLANES-1:0] plane_mask;
        logic                  culled;
    } t_cull;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ROW_W-1:0]      i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    t_row            mat_row [NUM_ROWS] = '{default: '0};
    logic [HH_W-1:0] half_h = HH_RESET;

    t_tile pending_tiles [$];
    t_cull expected_culls [$];
    int    errors = 0;
    int    idle_pct = 36;
    int    hold_req = 0;
    int    hold_left = 0;

    box_frustum_cull_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_cull cull_verdict(t_tile t);
        longint v [NUM_COLS];
        longint clip [NUM_ROWS];
        int     outside [NUM_PLANES];
        int     n;
        int     r;
        int     c;
        t_cull  res;
        outside = '{default: 0};
        for (n = 0; n < NUM_CORNERS; n++) begin
            v[0] = longint'(t.offset_x) + (n[2] ? longint'(t.tile_scale) : 64'sd0);
            v[1] = n[0] ? longint'(half_h) : -longint'(half_h);
            v[2] = longint'(t.offset_z) + (n[1] ? longint'(t.tile_scale) : 64'sd0);
            v[3] = 1;
            for (r = 0; r < NUM_ROWS; r++) begin
                clip[r] = 0;
                for (c = 0; c < NUM_COLS; c++)
                    clip[r] += longint'($signed(mat_row[r][COEF_W*c +: COEF_W])) * v[c];
            end
            if (clip[ROW_X] < -clip[ROW_W_IDX]) outside[PL_LEFT]++;
            if (clip[ROW_X] >  clip[ROW_W_IDX]) outside[PL_RIGHT]++;
            if (clip[ROW_Y] < -clip[ROW_W_IDX]) outside[PL_BOTTOM]++;
            if (clip[ROW_Y] >  clip[ROW_W_IDX]) outside[PL_TOP]++;
            if (clip[ROW_Z] < -clip[ROW_W_IDX]) outside[PL_NEAR]++;
            if (clip[ROW_Z] >  clip[ROW_W_IDX]) outside[PL_FAR]++;
        end
        res = '0;
        for (n = 0; n < NUM_PLANES; n++)
            res.plane_mask[n] = (outside[n] == NUM_CORNERS);
        res.culled = |res.plane_mask;
        return res;
    endfunction

    function automatic t_row random_row();
        t_row row;
        int   c;
        for (c = 0; c < NUM_COLS; c++) begin
            case ($urandom_range(0, 5))
                0: row[COEF_W*c +: COEF_W] = '0;
                1: row[COEF_W*c +: COEF_W] = COEF_W'($urandom_range(0, 1024)) - 16'd512;
                2: row[COEF_W*c +: COEF_W] = COEF_W'($urandom);
                3: row[COEF_W*c +: COEF_W] = 16'h8000;
                4: row[COEF_W*c +: COEF_W] = 16'h7FFF;
                default: row[COEF_W*c +: COEF_W] = $urandom_range(0, 1) ? 16'h0100 : 16'hFF00;
            endcase
        end
        return row;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_row data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HALF_HEIGHT)
            half_h = data[HH_W-1:0];
        else if (idx <= CFG_ROW3)
            mat_row[idx[1:0]] = data;
    endtask

    task automatic load_matrix(input t_row r0, input t_row r1, input t_row r2, input t_row r3,
                               input logic [HH_W-1:0] hh);
        write_reg(CFG_ROW0, r0);
        write_reg(CFG_ROW1, r1);
        write_reg(CFG_ROW2, r2);
        write_reg(CFG_ROW3, r3);
        write_reg(CFG_HALF_HEIGHT, ROW_W'(hh));
    endtask

    task automatic push_tile(input int scale, input int ox, input int oz);
        t_tile t;
        t.tile_scale = SCALE_W'(scale);
        t.offset_x   = OFFSET_W'(ox);
        t.offset_z   = OFFSET_W'(oz);
        pending_tiles = {pending_tiles, t};
    endtask

    task automatic push_extremes();
        push_tile(0, 0, 0);
        push_tile(32767, -32768, -32768);
        push_tile(32767, 32767, 32767);
        push_tile(0, -32768, 32767);
    endtask

    task automatic wait_drained();
        while (pending_tiles.size() != 0 || i_s_tvalid || expected_culls.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // tile driver
    always @(posedge i_clk) begin
        t_tile nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                expected_culls = {expected_culls,
                                  cull_verdict(t_tile'(i_s_tdata[$bits(t_tile)-1:0]))};
            if (i_s_tvalid && !o_s_tready) begin
                // hold the current transfer
            end else if (pending_tiles.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                nxt = pending_tiles.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {1'b0, nxt};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (hold_req > 0) begin
            hold_left  = hold_req;
            hold_req   = 0;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_cull want;
        t_cull got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_cull'(o_m_tdata);
            if (expected_culls.size() == 0) begin
                $display("%0t: unexpected result, actual %b", $realtime, o_m_tdata);
                errors++;
            end else begin
                want = expected_culls.pop_front();
                if (got.culled !== want.culled) begin
                    $display("%0t: culled expected %b actual %b",
                             $realtime, want.culled, got.culled);
                    errors++;
                end
                if (got.plane_mask !== want.plane_mask) begin
                    $display("%0t: plane_mask expected %b actual %b",
                             $realtime, want.plane_mask, got.plane_mask);
                    errors++;
                end
                if (got.pad !== want.pad) begin
                    $display("%0t: pad bit expected %b actual %b", $realtime, want.pad, got.pad);
                    errors++;
                end
            end
        end
    end

    initial begin
        int   n_rand;
        int   phase;
        int   cnt;
        int   k;
        int   scale;
        int   ox;
        int   oz;
        logic [HH_W-1:0] hh;
        logic [CFG_IDX_W-1:0] idx;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero matrix after reset: nothing is ever outside
        push_tile(0, 0, 0);
        push_tile(32767, -32768, 32767);
        push_tile(1, 32767, -32768);
        wait_drained();

        // corners exactly on the right plane: x == w
        load_matrix({16'h0100, 48'h0}, '0, '0, {16'h0100, 48'h0}, 15'h7FFF);
        push_extremes();
        wait_drained();

        // all right of x and in front of near
        load_matrix({16'h0101, 48'h0}, '0, {16'hFED4, 48'h0}, {16'h0100, 48'h0}, 15'd0);
        push_tile(100, -5, 7);
        push_tile(32767, -32768, -32768);
        push_tile(0, 32767, 0);
        wait_drained();

        // negative w with extreme coefficients
        load_matrix({16'h0000, 32'h0, 16'h7FFF}, {16'h0000, 16'h0, 16'h8000, 16'h0},
                    {16'h8000, 16'h0, 16'h7FFF, 16'h0}, {16'hFF00, 48'h0}, 15'd0);
        push_extremes();
        push_tile(3, -2, 1);
        push_tile(32767, 1, -1);
        wait_drained();

        // writes beyond the last register are dropped
        idx = CFG_HALF_HEIGHT;
        do begin
            idx = idx + 3'd1;
            write_reg(idx, {$urandom, $urandom});
        end while (idx != CFG_IDX_MAX);
        push_tile(5, 10, -10);
        push_tile(32767, -32768, 32767);
        wait_drained();

        n_rand = 0;
        phase  = 0;
        while (n_rand < 1650) begin
            idle_pct = (phase == 2) ? 0 : 36;
            if (phase % 3 != 1) begin
                case ($urandom_range(0, 3))
                    0: hh = '0;
                    1: hh = '1;
                    2: hh = HH_W'($urandom);
                    default: hh = HH_W'($urandom_range(0, 2000));
                endcase
                load_matrix(random_row(), random_row(), random_row(), random_row(), hh);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_MAX - CFG_IDX_W'($urandom_range(0, 2)), {$urandom, $urandom});
            if (phase == 5)
                hold_req = 300;
            cnt = (phase == 2) ? 300 : (phase == 5) ? 200 : $urandom_range(60, 180);
            if (cnt > 1650 - n_rand)
                cnt = 1650 - n_rand;
            for (k = 0; k < cnt; k++) begin
                case ($urandom_range(0, 9))
                    0:       scale = $urandom_range(0, 1) ? 32767 : 0;
                    1, 2:    scale = $urandom_range(0, 32767);
                    default: scale = $urandom_range(0, 255);
                endcase
                case ($urandom_range(0, 9))
                    0:       ox = $urandom_range(0, 1) ? 32767 : -32768;
                    1, 2, 3: ox = $urandom_range(0, 1023) - 512;
                    default: ox = $urandom_range(0, 65535) - 32768;
                endcase
                case ($urandom_range(0, 9))
                    0:       oz = $urandom_range(0, 1) ? 32767 : -32768;
                    1, 2, 3: oz = $urandom_range(0, 1023) - 512;
                    default: oz = $urandom_range(0, 65535) - 32768;
                endcase
                push_tile(scale, ox, oz);
            end
            n_rand += cnt;
            wait_drained();
            phase++;
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
